// File: src/dast_pkg.sv
// ----------------------------------------------------------------------------
// dast_pkg
// Shared types and constants for the device address slot table.
// ----------------------------------------------------------------------------
package dast_pkg;

    // Table geometry
    localparam int SLOTS            = 64;
    localparam int IDX_W            = $clog2(SLOTS);
    localparam int LONG_ADDR_BYTES  = 8;
    localparam int SHORT_ADDR_BYTES = 2;

    // Field widths of the request and response
    localparam int OP_W    = 4;
    localparam int SLOT_W  = 6;
    localparam int LONG_W  = 64;
    localparam int SHORT_W = 16;

    // Significant bits of the stored addresses
    localparam logic [LONG_W-1:0] LONG_MASK = (LONG_ADDR_BYTES >= 8) ? {LONG_W{1'b1}} :
        ((LONG_W'(1) << (8 * LONG_ADDR_BYTES)) - LONG_W'(1));
    localparam logic [SHORT_W-1:0] SHORT_MASK = (SHORT_ADDR_BYTES >= 2) ? 16'hFFFF :
        16'h00FF;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Operation codes on the request channel
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC      = 4'd0,
        OP_SET_SHORT  = 4'd1,
        OP_FREE       = 4'd2,
        OP_READ_LONG  = 4'd3,
        OP_READ_SHORT = 4'd4,
        OP_FIND_LONG  = 4'd5,
        OP_FIND_SHORT = 4'd6,
        OP_TEST       = 4'd7,
        OP_CLEAR      = 4'd8
    } op_t;

    // Classified command kinds handed from front to back
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_ALLOC,
        CMD_FIND_LONG,
        CMD_FIND_SHORT,
        CMD_SET_SHORT,
        CMD_FREE,
        CMD_REPORT,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [SLOT_W-1:0]  slot;
        logic [LONG_W-1:0]  long_addr;
        logic [SHORT_W-1:0] short_addr;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  found_slot;
        logic [LONG_W-1:0]  long_addr_out;
        logic [SHORT_W-1:0] short_addr_out;
        logic               in_use;
    } rsp_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [IDX_W-1:0]   idx;
        logic [LONG_W-1:0]  long_key;
        logic [SHORT_W-1:0] short_key;
    } cmd_t;

endpackage

// File: src/dast_ram.sv
// ----------------------------------------------------------------------------
// dast_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dast_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/dast_front.sv
// ----------------------------------------------------------------------------
// dast_front
// Request intake: decodes the operation, checks the slot range and masks
// the addresses into a command for the back end.
// ----------------------------------------------------------------------------
module dast_front
    import dast_pkg::*;
(
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    input  logic q_full,
    output logic push,
    output cmd_t cmd
);

    logic slot_ok;

    // Accept whenever the queue has room
    assign req_ready = !q_full;
    assign push      = req_valid && !q_full;

    assign slot_ok = int'(req.slot) < SLOTS;

    // Classify the transaction
    always_comb
    begin
        cmd.idx       = IDX_W'(req.slot);
        cmd.long_key  = req.long_addr & LONG_MASK;
        cmd.short_key = req.short_addr & SHORT_MASK;
        unique case (req.operation) inside
            OP_ALLOC:      cmd.kind = CMD_ALLOC;
            OP_FIND_LONG:  cmd.kind = CMD_FIND_LONG;
            OP_FIND_SHORT: cmd.kind = CMD_FIND_SHORT;
            OP_SET_SHORT:  cmd.kind = slot_ok ? CMD_SET_SHORT : CMD_NOP;
            OP_FREE:       cmd.kind = slot_ok ? CMD_FREE : CMD_NOP;
            OP_READ_LONG, OP_READ_SHORT, OP_TEST:
                           cmd.kind = slot_ok ? CMD_REPORT : CMD_NOP;
            OP_CLEAR:      cmd.kind = CMD_CLEAR;
            default:       cmd.kind = CMD_NOP;
        endcase
    end

endmodule

// File: src/dast_queue.sv
// ----------------------------------------------------------------------------
// dast_queue
// Short command FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module dast_queue
    import dast_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic not_empty
);

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = count_reg == Q_CNT_W'(Q_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && not_empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == Q_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == Q_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/dast_back.sv
// ----------------------------------------------------------------------------
// dast_back
// Command execution: owns the in-use marks and address stores, runs the
// allocate and find scans, and holds the response register.
// ----------------------------------------------------------------------------
module dast_back
    import dast_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_not_empty,
    input  cmd_t q_head,
    output logic pop,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_RD   = 4'b0100,
        ST_FORM = 4'b1000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [IDX_W-1:0] rep_reg, rep_next;
    logic             have_reg, have_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             issue_done_reg, issue_done_next;
    logic [SLOTS-1:0] used_reg, used_next;
    logic [SLOTS-1:0] long_wr_reg, long_wr_next;
    logic [SLOTS-1:0] short_wr_reg, short_wr_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               long_we, short_we;
    logic [IDX_W-1:0]   long_wr_addr, short_wr_addr;
    logic [LONG_W-1:0]  long_wdata, long_rdata, long_val;
    logic [SHORT_W-1:0] short_wdata, short_rdata, short_val;
    logic [LONG_W-1:0]  cmp_long;
    logic [SHORT_W-1:0] cmp_short;
    logic               match;
    logic               is_search;

    dast_ram #(
        .WIDTH (LONG_W),
        .DEPTH (SLOTS)
    ) u_long_ram (
        .clk     (clk),
        .wr_en   (long_we),
        .wr_addr (long_wr_addr),
        .wr_data (long_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (long_rdata)
    );

    dast_ram #(
        .WIDTH (SHORT_W),
        .DEPTH (SLOTS)
    ) u_short_ram (
        .clk     (clk),
        .wr_en   (short_we),
        .wr_addr (short_wr_addr),
        .wr_data (short_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (short_rdata)
    );

    // Compare the entry read in the previous scan cycle; unwritten reads zero
    assign cmp_long  = long_wr_reg[cmp_idx_reg] ? long_rdata : '0;
    assign cmp_short = short_wr_reg[cmp_idx_reg] ? short_rdata : '0;

    always_comb
    begin
        case (cmd_reg.kind)
            CMD_ALLOC:      match = !used_reg[cmp_idx_reg];
            CMD_FIND_LONG:  match = used_reg[cmp_idx_reg] && (cmp_long == cmd_reg.long_key);
            CMD_FIND_SHORT: match = used_reg[cmp_idx_reg] &&
                                    (cmp_short == cmd_reg.short_key);
            default:        match = 1'b0;
        endcase
    end

    // Reported contents after the report read
    assign long_val  = long_wr_reg[rep_reg] ? long_rdata : '0;
    assign short_val = short_wr_reg[rep_reg] ? short_rdata : '0;
    assign is_search = (cmd_reg.kind == CMD_ALLOC) || (cmd_reg.kind == CMD_FIND_LONG) ||
                       (cmd_reg.kind == CMD_FIND_SHORT);

    assign rd_addr = (state_reg == ST_SCAN) ? scan_idx_reg : rep_reg;

    // Sequence each command
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        rep_next        = rep_reg;
        have_next       = have_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = 1'b0;
        issue_done_next = issue_done_reg;
        used_next       = used_reg;
        long_wr_next    = long_wr_reg;
        short_wr_next   = short_wr_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        pop             = 1'b0;
        rd_en           = 1'b0;
        long_we         = 1'b0;
        long_wr_addr    = cmp_idx_reg;
        long_wdata      = cmd_reg.long_key;
        short_we        = 1'b0;
        short_wr_addr   = q_head.idx;
        short_wdata     = q_head.short_key;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    pop       = 1'b1;
                    cmd_next  = q_head;
                    rep_next  = q_head.idx;
                    have_next = 1'b1;
                    unique case (q_head.kind) inside
                        CMD_ALLOC, CMD_FIND_LONG, CMD_FIND_SHORT:
                        begin
                            scan_idx_next   = IDX_W'(1);
                            issue_done_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        CMD_SET_SHORT:
                        begin
                            short_we                = 1'b1;
                            short_wr_next[q_head.idx] = 1'b1;
                            state_next              = ST_RD;
                        end
                        CMD_FREE:
                        begin
                            used_next[q_head.idx] = 1'b0;
                            state_next            = ST_RD;
                        end
                        CMD_REPORT:
                        begin
                            state_next = ST_RD;
                        end
                        CMD_CLEAR:
                        begin
                            used_next  = '0;
                            have_next  = 1'b0;
                            state_next = ST_FORM;
                        end
                        default:
                        begin
                            have_next  = 1'b0;
                            state_next = ST_FORM;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (cmp_valid_reg && match)
                begin
                    // Hit: commit an allocation for an allocate, then report
                    rep_next   = cmp_idx_reg;
                    have_next  = 1'b1;
                    state_next = ST_RD;
                    if (cmd_reg.kind == CMD_ALLOC)
                    begin
                        long_we                   = 1'b1;
                        used_next[cmp_idx_reg]    = 1'b1;
                        long_wr_next[cmp_idx_reg] = 1'b1;
                    end
                end
                else if (cmp_valid_reg && (cmp_idx_reg == LAST_IDX))
                begin
                    have_next  = 1'b0;
                    state_next = ST_FORM;
                end
                else if (!issue_done_reg)
                begin
                    // Issue the next entry read
                    rd_en          = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg;
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end

            ST_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_FORM;
            end

            ST_FORM:
            begin
                // Load the response register once it is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    if (have_reg)
                    begin
                        rsp_next.found_slot     = is_search ? SLOT_W'(rep_reg) : '0;
                        rsp_next.long_addr_out  = long_val;
                        rsp_next.short_addr_out = short_val;
                        rsp_next.in_use         = used_reg[rep_reg];
                    end
                    else
                    begin
                        rsp_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmp_valid_reg  <= 1'b0;
            issue_done_reg <= 1'b0;
            used_reg       <= '0;
            long_wr_reg    <= '0;
            short_wr_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmp_valid_reg  <= cmp_valid_next;
            issue_done_reg <= issue_done_next;
            used_reg       <= used_next;
            long_wr_reg    <= long_wr_next;
            short_wr_reg   <= short_wr_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        rep_reg      <= rep_next;
        have_reg     <= have_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: src/device_address_slot_table_top.sv
// ----------------------------------------------------------------------------
// device_address_slot_table_top
// Slot table binding long and short device addresses to slot numbers.
//
//   channel  signals                        payload
//   req      req_valid / req_ready          req_t (operation, slot, addrs)
//   rsp      rsp_valid / rsp_ready          rsp_t (found_slot, addrs, in_use)
//
// Set short, free, read and test pass through the back-end states IDLE, RD and
// FORM; clear and unknown operations go from IDLE to FORM. Allocate and the two
// finds scan slots 1 to SLOTS-1, one RAM read per cycle, ending early on a hit.
// Reset clears the in-use and per-slot written marks at once; unwritten
// address entries read as zero, so no clearing pass is needed.
// A two-entry command queue takes requests while the back end is busy or a
// response waits in its output register.
// ----------------------------------------------------------------------------
module device_address_slot_table_top
    import dast_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_not_empty;
    logic pop;
    cmd_t q_head;

    dast_front u_front (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_full    (q_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    dast_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head      (q_head),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    dast_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

endmodule
